@@ hw/rtl/sh2thp_pkg.sv @@
// Shared types and constants for the SH-2 task header profiler.
package sh2thp_pkg;

  localparam int unsigned SpineLen = 36;
  localparam int unsigned MinSize  = 64;

  localparam logic [7:0] SPINE [SpineLen] = '{
    8'h2f, 8'he6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h34, 8'h23,
    8'h4f, 8'h22, 8'h7f, 8'hfc, 8'h2f, 8'h52, 8'h8d, 8'h02,
    8'h23, 8'h42, 8'h44, 8'h11, 8'h89, 8'h04, 8'he0, 8'hff,
    8'h7f, 8'h04, 8'h4f, 8'h26, 8'h00, 8'h0b, 8'h6e, 8'hf6,
    8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [15:0] ENTRY_WORD   = 16'h2fe6;
  localparam logic [15:0] OP_RTS       = 16'h000b;
  localparam logic [15:0] JSR_MASK     = 16'hf0ff;
  localparam logic [15:0] OP_JSR       = 16'h400b;
  localparam logic [3:0]  NIB_BRA      = 4'ha;
  localparam logic [3:0]  NIB_BSR      = 4'hb;
  localparam logic [3:0]  NIB_MOVI     = 4'he;
  localparam logic [3:0]  NIB_MOVW     = 4'h9;
  localparam logic [3:0]  NIB_MOVL     = 4'hd;
  localparam logic [15:0] WIN_HIGH     = 16'h0020;

  localparam logic [4:0] REP_PROFILE_OK = 5'd0;
  localparam logic [4:0] REP_WORDS      = 5'd1;
  localparam logic [4:0] REP_FIRST_OP   = 5'd2;
  localparam logic [4:0] REP_RTS        = 5'd3;
  localparam logic [4:0] REP_BRANCH     = 5'd4;
  localparam logic [4:0] REP_IMM        = 5'd5;
  localparam logic [4:0] REP_JSR        = 5'd6;
  localparam logic [4:0] REP_PCREL      = 5'd7;
  localparam logic [4:0] REP_WIN_CNT    = 5'd8;
  localparam logic [4:0] REP_WIN_OFF    = 5'd9;
  localparam logic [4:0] REP_WIN_FIRST  = 5'd10;
  localparam logic [4:0] REP_WIN_LAST   = 5'd11;
  localparam logic [4:0] REP_SUM        = 5'd12;
  localparam logic [4:0] REP_HDR_OK     = 5'd13;
  localparam logic [4:0] REP_SETUP_IMM  = 5'd14;
  localparam logic [4:0] REP_PRI_DISP   = 5'd15;
  localparam logic [4:0] REP_PRI_OFF    = 5'd16;
  localparam logic [4:0] REP_PRI_LIT    = 5'd17;
  localparam logic [4:0] REP_AUX_DISP   = 5'd18;
  localparam logic [4:0] REP_AUX_OFF    = 5'd19;
  localparam logic [4:0] REP_AUX_LIT    = 5'd20;

  // Class counter slots
  localparam int unsigned CntRts    = 0;
  localparam int unsigned CntBranch = 1;
  localparam int unsigned CntImm    = 2;
  localparam int unsigned CntJsr    = 3;
  localparam int unsigned CntPcrel  = 4;
  localparam int unsigned CntWin    = 5;
  localparam int unsigned NumCnt    = 6;

endpackage

@@ hw/rtl/sh2_task_header_profiler_core.sv @@
// Top level of the SH-2 task header profiler: byte intake, snapshot and report sequencer.
// Takes one file byte per cycle while s_axis_tready is high. Each byte passes through one
// stage of word classification, sum, window and header-spine checks into the per-file
// registers. On the last byte the file state is copied into a report bank and cleared, so
// the next file streams in at once while the 21 reports leave from the bank, one per cycle
// while the sink is ready, through the output register. A last byte of a following file
// waits while the bank still has reports to send. A taken last byte loads the bank and
// marks it busy, and the first report then goes from the bank into the output register.
module sh2_task_header_profiler_core #(
  parameter int unsigned MAX_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // verified_source
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,    // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [31:0] report_value
  output logic [4:0]  m_axis_tuser,    // [4:0] report_index
  output logic        m_axis_tlast     // last_report
);

  localparam int unsigned PosW = $clog2(MAX_BYTES + 2);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_BYTES);

  // configuration
  logic ver_q;

  // per-file state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [23:0]      recent_q, recent_d;
  logic             spine_q, spine_d;
  logic [7:0]       hb_q [3];
  logic [7:0]       hb_d [3];
  logic [31:0]      lit_q [2];
  logic [31:0]      lit_d [2];
  logic [15:0]      sum_q, sum_d;
  logic [PosW-1:0]  cnt_q [sh2thp_pkg::NumCnt];
  logic [PosW-1:0]  cnt_d [sh2thp_pkg::NumCnt];
  logic [PosW-1:0]  woff_q, woff_d;
  logic [31:0]      waddr_q [2];
  logic [31:0]      waddr_d [2];

  // report bank
  logic             busy_q;
  logic [4:0]       step_q;
  logic             b_ver_q;
  logic [PosW-1:0]  b_size_q;
  logic             b_spine_q;
  logic [7:0]       b_hb_q [3];
  logic [31:0]      b_lit_q [2];
  logic [15:0]      b_sum_q;
  logic [PosW-1:0]  b_cnt_q [sh2thp_pkg::NumCnt];
  logic [PosW-1:0]  b_woff_q;
  logic [31:0]      b_waddr_q [2];

  // output register
  logic             m_valid_q;
  logic [31:0]      m_data_q;
  logic [4:0]       m_user_q;
  logic             m_last_q;

  logic             in_acc;
  logic             in_last_acc;
  logic             take;
  logic [5:0]       spos;
  logic [15:0]      word;
  logic [31:0]      win;
  logic [3:0]       nib;
  logic             win_hit;
  logic [31:0]      pos32;
  logic [31:0]      lit0_pos;
  logic [31:0]      lit1_pos;

  assign s_axis_tready = !busy_q || !s_axis_tlast;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_last_acc   = in_acc && s_axis_tlast;

  assign take     = pos_q < MaxPos;
  assign spos     = pos_q[5:0];
  assign word     = {recent_q[7:0], s_axis_tdata};
  assign win      = {recent_q, s_axis_tdata};
  assign nib      = word[15:12];
  assign win_hit  = win[31:16] == sh2thp_pkg::WIN_HIGH;
  assign pos32    = 32'(pos_q);
  assign lit0_pos = 32'd11 + {22'd0, hb_q[1], 2'b00};
  assign lit1_pos = 32'd39 + {22'd0, hb_q[2], 2'b00};

  // per-byte update
  always_comb begin
    logic free_byte;
    pos_d    = pos_q;
    recent_d = recent_q;
    spine_d  = spine_q;
    hb_d     = hb_q;
    lit_d    = lit_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    woff_d   = woff_q;
    waddr_d  = waddr_q;
    free_byte = 1'b0;
    if (!take) begin
      pos_d = MaxPos + PosW'(1);
    end else begin
      pos_d    = pos_q + PosW'(1);
      recent_d = {recent_q[15:0], s_axis_tdata};
      if (pos_q < PosW'(sh2thp_pkg::SpineLen)) begin
        free_byte = (spos >= 6'd2 && spos <= 6'd5) || spos >= 6'd32;
        if (!free_byte && s_axis_tdata != sh2thp_pkg::SPINE[spos]) begin
          spine_d = 1'b0;
        end
        if (spos == 6'd2 && s_axis_tdata[7:4] != sh2thp_pkg::NIB_MOVI) begin
          spine_d = 1'b0;
        end
        if ((spos == 6'd4 || spos == 6'd32) && s_axis_tdata[7:4] != sh2thp_pkg::NIB_MOVL) begin
          spine_d = 1'b0;
        end
        if (spos == 6'd3) begin
          hb_d[0] = s_axis_tdata;
        end
        if (spos == 6'd5) begin
          hb_d[1] = s_axis_tdata;
        end
        if (spos == 6'd33) begin
          hb_d[2] = s_axis_tdata;
        end
      end
      if (pos_q[0]) begin
        sum_d = sum_q + word;
        if (word == sh2thp_pkg::OP_RTS) begin
          cnt_d[sh2thp_pkg::CntRts] = cnt_q[sh2thp_pkg::CntRts] + PosW'(1);
        end
        if (nib == sh2thp_pkg::NIB_BRA || nib == sh2thp_pkg::NIB_BSR) begin
          cnt_d[sh2thp_pkg::CntBranch] = cnt_q[sh2thp_pkg::CntBranch] + PosW'(1);
        end
        if (nib == sh2thp_pkg::NIB_MOVI) begin
          cnt_d[sh2thp_pkg::CntImm] = cnt_q[sh2thp_pkg::CntImm] + PosW'(1);
        end
        if ((word & sh2thp_pkg::JSR_MASK) == sh2thp_pkg::OP_JSR) begin
          cnt_d[sh2thp_pkg::CntJsr] = cnt_q[sh2thp_pkg::CntJsr] + PosW'(1);
        end
        if (nib == sh2thp_pkg::NIB_MOVW || nib == sh2thp_pkg::NIB_MOVL) begin
          cnt_d[sh2thp_pkg::CntPcrel] = cnt_q[sh2thp_pkg::CntPcrel] + PosW'(1);
        end
        if (pos_q >= PosW'(3)) begin
          if (win_hit) begin
            if (cnt_q[sh2thp_pkg::CntWin] == '0) begin
              woff_d     = pos_q - PosW'(3);
              waddr_d[0] = win;
            end
            waddr_d[1] = win;
            cnt_d[sh2thp_pkg::CntWin] = cnt_q[sh2thp_pkg::CntWin] + PosW'(1);
          end
          if (pos32 == lit0_pos) begin
            lit_d[0] = win;
          end
          if (pos32 == lit1_pos) begin
            lit_d[1] = win;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q <= 1'b0;
    end else if (cfg_we_i) begin
      ver_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      recent_q <= '0;
      spine_q  <= 1'b1;
      hb_q     <= '{default: '0};
      lit_q    <= '{default: '0};
      sum_q    <= '0;
      cnt_q    <= '{default: '0};
      woff_q   <= '0;
      waddr_q  <= '{default: '0};
    end else if (in_last_acc) begin
      pos_q    <= '0;
      recent_q <= '0;
      spine_q  <= 1'b1;
      hb_q     <= '{default: '0};
      lit_q    <= '{default: '0};
      sum_q    <= '0;
      cnt_q    <= '{default: '0};
      woff_q   <= '0;
      waddr_q  <= '{default: '0};
    end else if (in_acc) begin
      pos_q    <= pos_d;
      recent_q <= recent_d;
      spine_q  <= spine_d;
      hb_q     <= hb_d;
      lit_q    <= lit_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      woff_q   <= woff_d;
      waddr_q  <= waddr_d;
    end
  end

  // snapshot of the finished file
  always_ff @(posedge clk_i) begin
    if (in_last_acc) begin
      b_ver_q   <= ver_q;
      b_size_q  <= pos_d;
      b_spine_q <= spine_d;
      b_hb_q    <= hb_d;
      b_lit_q   <= lit_d;
      b_sum_q   <= sum_d;
      b_cnt_q   <= cnt_d;
      b_woff_q  <= woff_d;
      b_waddr_q <= waddr_d;
    end
  end

  // gates
  logic [31:0] size32;
  logic [31:0] poff32;
  logic [31:0] aoff32;
  logic        base_ok;
  logic        header_ok;
  logic        profile_ok;
  logic        have_win;

  assign size32  = 32'(b_size_q);
  assign poff32  = 32'd8 + {22'd0, b_hb_q[1], 2'b00};
  assign aoff32  = 32'd36 + {22'd0, b_hb_q[2], 2'b00};
  assign base_ok = b_ver_q && size32 >= 32'(sh2thp_pkg::MinSize) && !b_size_q[0] &&
                   b_size_q <= MaxPos;
  assign header_ok = base_ok && b_spine_q &&
                     poff32 >= 32'(sh2thp_pkg::SpineLen) &&
                     aoff32 >= 32'(sh2thp_pkg::SpineLen) &&
                     poff32 + 32'd4 <= size32 && aoff32 + 32'd4 <= size32 &&
                     b_lit_q[0][31:16] == sh2thp_pkg::WIN_HIGH &&
                     b_lit_q[1][31:16] == sh2thp_pkg::WIN_HIGH;
  assign profile_ok = header_ok && b_cnt_q[sh2thp_pkg::CntRts] != '0;
  assign have_win   = b_cnt_q[sh2thp_pkg::CntWin] != '0;

  logic [31:0] rep_val;

  always_comb begin
    rep_val = '0;
    case (step_q)
      sh2thp_pkg::REP_PROFILE_OK: rep_val = {31'd0, profile_ok};
      sh2thp_pkg::REP_WORDS:      rep_val = profile_ok ? (size32 >> 1) : '0;
      sh2thp_pkg::REP_FIRST_OP:   rep_val = profile_ok ? {16'd0, sh2thp_pkg::ENTRY_WORD} : '0;
      sh2thp_pkg::REP_RTS:        rep_val = profile_ok ? 32'(b_cnt_q[sh2thp_pkg::CntRts]) : '0;
      sh2thp_pkg::REP_BRANCH:     rep_val = profile_ok ? 32'(b_cnt_q[sh2thp_pkg::CntBranch]) : '0;
      sh2thp_pkg::REP_IMM:        rep_val = profile_ok ? 32'(b_cnt_q[sh2thp_pkg::CntImm]) : '0;
      sh2thp_pkg::REP_JSR:        rep_val = profile_ok ? 32'(b_cnt_q[sh2thp_pkg::CntJsr]) : '0;
      sh2thp_pkg::REP_PCREL:      rep_val = profile_ok ? 32'(b_cnt_q[sh2thp_pkg::CntPcrel]) : '0;
      sh2thp_pkg::REP_WIN_CNT:    rep_val = profile_ok ? 32'(b_cnt_q[sh2thp_pkg::CntWin]) : '0;
      sh2thp_pkg::REP_WIN_OFF:    rep_val = (profile_ok && have_win) ? 32'(b_woff_q) : '1;
      sh2thp_pkg::REP_WIN_FIRST:  rep_val = (profile_ok && have_win) ? b_waddr_q[0] : '0;
      sh2thp_pkg::REP_WIN_LAST:   rep_val = (profile_ok && have_win) ? b_waddr_q[1] : '0;
      sh2thp_pkg::REP_SUM:        rep_val = profile_ok ? {16'd0, b_sum_q} : '0;
      sh2thp_pkg::REP_HDR_OK:     rep_val = {31'd0, header_ok};
      sh2thp_pkg::REP_SETUP_IMM:  rep_val = header_ok ? {24'd0, b_hb_q[0]} : '0;
      sh2thp_pkg::REP_PRI_DISP:   rep_val = header_ok ? {24'd0, b_hb_q[1]} : '0;
      sh2thp_pkg::REP_PRI_OFF:    rep_val = header_ok ? poff32 : '1;
      sh2thp_pkg::REP_PRI_LIT:    rep_val = header_ok ? b_lit_q[0] : '0;
      sh2thp_pkg::REP_AUX_DISP:   rep_val = header_ok ? {24'd0, b_hb_q[2]} : '0;
      sh2thp_pkg::REP_AUX_OFF:    rep_val = header_ok ? aoff32 : '1;
      sh2thp_pkg::REP_AUX_LIT:    rep_val = header_ok ? b_lit_q[1] : '0;
      default:                    rep_val = '0;
    endcase
  end

  logic emit;
  assign emit = busy_q && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (in_last_acc) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (emit) begin
        if (step_q == sh2thp_pkg::REP_AUX_LIT) begin
          busy_q <= 1'b0;
          step_q <= '0;
        end else begin
          step_q <= step_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= rep_val;
      m_user_q <= step_q;
      m_last_q <= step_q == sh2thp_pkg::REP_AUX_LIT;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule
